FILE: rtl/core/hdlc_dfr_pkg.sv
// Shared constants and controller/datapath interface types for the HDLC deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package hdlc_dfr_pkg;

  // Framing octets
  localparam logic [7:0] FLAG_OCTET = 8'h7E;
  localparam logic [7:0] ESC_OCTET  = 8'h7D;
  localparam logic [7:0] FLIP_BITS  = 8'h20;

  // Stored byte count and frame length width (holds 0..64)
  localparam int CNT_W = 7;

  // Default packet buffer size
  localparam int PACKET_BYTES_DEF = 64;

  // Configuration register file
  localparam int               ADDR_W         = 3;
  localparam logic             REG_MIN_FRAME  = 1'b0;
  localparam logic [CNT_W-1:0] MIN_FRAME_RST  = 7'd8;

  // Controller to datapath commands
  typedef struct packed {
    logic take_input;  // input channel open
    logic send;        // walk the buffer toward the output
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start;       // accepted flag closes a frame long enough to deliver
    logic read_last;   // final buffer entry moved into the output register
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/hdlc_async_deframer.sv
// HDLC asynchronous deframer. A flag that closes a long enough frame starts
// delivery of the whole buffer, PACKET_BYTES requests at one per cycle set by
// the single buffer read port while out_stall is low; the controller registers
// the send command, then the output register loads the first. Input waits meanwhile.
// Reset is synchronous: control, count and per-entry valid bits clear at once,
// so the buffer reads as zeros with no clearing pass.
`default_nettype none

module hdlc_async_deframer #(
  parameter int PACKET_BYTES = hdlc_dfr_pkg::PACKET_BYTES_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [hdlc_dfr_pkg::ADDR_W-1:0]   paddr,
  input  wire [31:0]                       pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // received bytes
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [7:0]                        rx_byte,
  // delivered packet bytes
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [7:0]                       pkt_byte,
  output logic [5:0]                       byte_index,
  output logic [hdlc_dfr_pkg::CNT_W-1:0]   frame_len,
  output logic                             last
);
  import hdlc_dfr_pkg::*;

  logic [CNT_W-1:0] min_frame_bytes;
  ctl_cmd_t         cmd;
  dp_stat_t         stat;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_bytes <= MIN_FRAME_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ADDR_W-1] == REG_MIN_FRAME)) begin
      min_frame_bytes <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_MIN_FRAME) begin
      prdata = {{(32-CNT_W){1'b0}}, min_frame_bytes};
    end
  end

  assign in_stall = ~cmd.take_input;

  hdlc_dfr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  hdlc_dfr_dpath #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .min_frame_bytes (min_frame_bytes),
    .in_valid        (in_valid),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pkt_byte        (pkt_byte),
    .byte_index      (byte_index),
    .frame_len       (frame_len),
    .last            (last)
  );

endmodule

`default_nettype wire

FILE: rtl/core/hdlc_dfr_ctrl.sv
// Controller of the HDLC deframer: switches between receiving and delivering.
// Depends on hdlc_dfr_pkg for the command and status types.
`default_nettype none

module hdlc_dfr_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire hdlc_dfr_pkg::dp_stat_t stat,
  output hdlc_dfr_pkg::ctl_cmd_t cmd
);
  import hdlc_dfr_pkg::*;

  typedef enum logic {
    S_RECV,
    S_SEND
  } state_t;

  state_t state;

  // Hold state and registered commands
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_RECV;
      cmd.take_input <= 1'b1;
      cmd.send       <= 1'b0;
    end else begin
      case (state)
        S_RECV: begin
          if (stat.start) begin
            state          <= S_SEND;
            cmd.take_input <= 1'b0;
            cmd.send       <= 1'b1;
          end
        end
        S_SEND: begin
          if (stat.read_last) begin
            state          <= S_RECV;
            cmd.take_input <= 1'b1;
            cmd.send       <= 1'b0;
          end
        end
        default: begin
          state          <= S_RECV;
          cmd.take_input <= 1'b1;
          cmd.send       <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hdlc_dfr_dpath.sv
// Datapath of the HDLC deframer: unstuffing, packet buffer, count and output register.
// Depends on hdlc_dfr_pkg for octet constants and the command and status types.
`default_nettype none

module hdlc_dfr_dpath #(
  parameter int PACKET_BYTES = hdlc_dfr_pkg::PACKET_BYTES_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire hdlc_dfr_pkg::ctl_cmd_t      cmd,
  output hdlc_dfr_pkg::dp_stat_t           stat,
  input  wire [hdlc_dfr_pkg::CNT_W-1:0]    min_frame_bytes,
  input  wire                              in_valid,
  input  wire [7:0]                        rx_byte,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [7:0]                       pkt_byte,
  output logic [5:0]                       byte_index,
  output logic [hdlc_dfr_pkg::CNT_W-1:0]   frame_len,
  output logic                             last
);
  import hdlc_dfr_pkg::*;

  localparam int IDX_W = $clog2(PACKET_BYTES);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PACKET_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

  // Packet buffer; entries not yet written read as zero through their valid bit
  logic [7:0]              mem [PACKET_BYTES];
  logic [PACKET_BYTES-1:0] entry_valid;

  logic             escape_pending;
  logic [CNT_W-1:0] stored_count;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] len_hold;

  // Output register
  logic [7:0]       mem_q;
  logic             valid_q;
  logic [IDX_W-1:0] out_idx;

  logic       accept;
  logic       is_flag;
  logic       is_esc;
  logic       do_store;
  logic [7:0] store_byte;
  logic       load;

  // Decode the incoming byte
  always_comb begin
    accept     = in_valid && cmd.take_input;
    is_flag    = (rx_byte == FLAG_OCTET);
    is_esc     = (rx_byte == ESC_OCTET);
    do_store   = 1'b0;
    store_byte = rx_byte;
    if (escape_pending) begin
      do_store   = 1'b1;
      store_byte = is_flag ? rx_byte : (rx_byte ^ FLIP_BITS);
    end else if (!is_flag && !is_esc) begin
      do_store = 1'b1;
    end
  end

  assign stat.start = accept && is_flag && !escape_pending &&
                      (stored_count >= min_frame_bytes);
  assign load           = cmd.send && (!out_valid || !out_stall);
  assign stat.read_last = load && (rd_idx == LAST_IDX);

  // Track escape and stored count; write the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      stored_count   <= '0;
      entry_valid    <= '0;
    end else if (accept) begin
      if (escape_pending) begin
        escape_pending <= 1'b0;
      end else if (is_flag) begin
        stored_count <= '0;
      end else if (is_esc) begin
        escape_pending <= 1'b1;
      end
      if (do_store && (stored_count < FULL_CNT)) begin
        stored_count                           <= stored_count + 1'b1;
        entry_valid[stored_count[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_store && (stored_count < FULL_CNT)) begin
      mem[stored_count[IDX_W-1:0]] <= store_byte;
    end
  end

  // Latch the frame length when a delivery starts
  always_ff @(posedge clk) begin
    if (stat.start) begin
      len_hold <= stored_count;
    end
  end

  // Advance the read pointer and fill the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        rd_idx    <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mem_q     <= mem[rd_idx];
      valid_q   <= entry_valid[rd_idx];
      out_idx   <= rd_idx;
      frame_len <= len_hold;
      last      <= (rd_idx == LAST_IDX);
    end
  end

  assign pkt_byte   = valid_q ? mem_q : 8'h00;
  assign byte_index = 6'(out_idx);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for hdlc_async_deframer: directed frames, then random frames.
// Checks every delivered packet byte against an in-bench unstuffing model.
// Depends on hdlc_dfr_pkg and the hdlc_async_deframer RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlc_dfr_pkg::*;

  localparam int PKT_BYTES = PACKET_BYTES_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [ADDR_W-1:0] MIN_FRAME_ADDR = ADDR_W'({REG_MIN_FRAME, 2'b00});

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // one directed step: a received byte or a new frame minimum
  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    logic       typed;     // outcome below is written out by hand
    logic       delivers;  // flag delivers the packet store
    logic [6:0] len;       // frame length of that delivery
  } dir_row_t;

  // one delivered packet byte
  typedef struct packed {
    logic [7:0]       data;
    logic [5:0]       index;
    logic [CNT_W-1:0] len;
    logic             last;
  } pkt_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             rx_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             pkt_byte;
  logic [5:0]             byte_index;
  logic [CNT_W-1:0]       frame_len;
  logic                   last;

  // deframer model state
  logic                   pred_esc;
  logic [6:0]             pred_count;
  logic [6:0]             pred_min;
  logic [6:0]             pred_len;
  logic [7:0]             pred_store [PKT_BYTES];
  pkt_beat_t              pending_bytes_q [$];

  int                     err_cnt;
  int                     beats_seen;
  int                     bytes_sent;
  int                     cycle_cnt;
  bit                     burst_tx;
  bit                     burst_rx;
  int                     stall_left;
  int                     hold_left;
  bit                     hold_done;
  pkt_beat_t              beat_want;
  pkt_beat_t              beat_got;

  dir_row_t dir_rows [25] = '{
    '{ROW_BYTE, FLAG_OCTET,             1'b1, 1'b0, 7'd0},
    '{ROW_BYTE, 8'h00,                  1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, 8'hFF,                  1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, ESC_OCTET,              1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, FLAG_OCTET ^ FLIP_BITS, 1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, ESC_OCTET,              1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, ESC_OCTET ^ FLIP_BITS,  1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, ESC_OCTET,              1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, FLAG_OCTET,             1'b1, 1'b0, 7'd0},
    '{ROW_BYTE, ESC_OCTET,              1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, ESC_OCTET,              1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, 8'h01,                  1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, 8'h80,                  1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, FLAG_OCTET,             1'b1, 1'b1, 7'd8},
    '{ROW_BYTE, 8'hAA,                  1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, FLAG_OCTET,             1'b1, 1'b0, 7'd0},
    '{ROW_CFG,  8'd1,                   1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, 8'h55,                  1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, FLAG_OCTET,             1'b1, 1'b1, 7'd1},
    '{ROW_CFG,  8'd0,                   1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, FLAG_OCTET,             1'b1, 1'b1, 7'd0},
    '{ROW_CFG,  8'd127,                 1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, 8'h33,                  1'b0, 1'b0, 7'd0},
    '{ROW_BYTE, FLAG_OCTET,             1'b1, 1'b0, 7'd0},
    '{ROW_CFG,  8'd64,                  1'b0, 1'b0, 7'd0}
  };

  hdlc_async_deframer u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pkt_byte   (pkt_byte),
    .byte_index (byte_index),
    .frame_len  (frame_len),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Unstuff one received byte; queue the whole store when a flag closes a long enough frame.
  function automatic int unstuff_byte(input logic [7:0] rx);
    logic [7:0] b;
    pkt_beat_t  beat;
    int         i;
    b = rx;
    if (rx == FLAG_OCTET && !pred_esc) begin
      if (pred_count >= pred_min) begin
        for (i = 0; i < PKT_BYTES; i++) begin
          beat.data  = pred_store[i];
          beat.index = 6'(i);
          beat.len   = pred_count;
          beat.last  = (i == PKT_BYTES - 1);
          pending_bytes_q.push_back(beat);
        end
        pred_len   = pred_count;
        pred_count = '0;
        return PKT_BYTES;
      end
      pred_count = '0;
      return 0;
    end
    // an escaped flag is kept raw and the frame goes on
    if (rx == FLAG_OCTET) begin
      pred_esc = 1'b0;
    end else if (pred_esc) begin
      pred_esc = 1'b0;
      b = rx ^ FLIP_BITS;
    end else if (rx == ESC_OCTET) begin
      pred_esc = 1'b1;
      return 0;
    end
    // drop bytes once the store is full
    if (pred_count < PKT_BYTES) begin
      pred_store[pred_count[5:0]] = b;
      pred_count = pred_count + 7'd1;
    end
    return 0;
  endfunction

  // Pick a sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_tx || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request and hold it until accepted; then run the model on it.
  task automatic send_byte(input logic [7:0] b, output int n_beats);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_beats = unstuff_byte(b);
    bytes_sent++;
  endtask

  // Wait for all deliveries, then write and read back the frame minimum.
  task automatic set_min_frame(input logic [6:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIN_FRAME_ADDR;
    pwdata  <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pred_min = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[6:0] !== v) begin
      $display("%0t: min_frame_bytes readback expected %0d got %0d", $time, v, prdata[6:0]);
      err_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Send one frame of roughly n_data payload bytes with stuffing, quirks and noise.
  task automatic send_frame(input int n_data);
    int i;
    int r;
    int d;
    int n;
    for (i = 0; i < n_data; i++) begin
      r = $urandom_range(0, 99);
      d = $urandom_range(0, 255);
      if (r < 4) begin
        // escape then flag: flag is stored raw
        send_byte(ESC_OCTET, n);
        send_byte(FLAG_OCTET, n);
      end else if (r < 7) begin
        // raw line noise, may break the frame
        send_byte(8'(d), n);
      end else begin
        if (r < 14) d = (r < 10) ? FLAG_OCTET : ESC_OCTET;
        if (d == FLAG_OCTET || d == ESC_OCTET || r >= 90) begin
          send_byte(ESC_OCTET, n);
          send_byte(8'(d) ^ FLIP_BITS, n);
        end else begin
          send_byte(8'(d), n);
        end
      end
    end
    send_byte(FLAG_OCTET, n);
  endtask

  // Check each accepted packet byte against the oldest pending one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      beat_got = '{pkt_byte, byte_index, frame_len, last};
      if (pending_bytes_q.size() == 0) begin
        $display("%0t: unexpected packet byte: data %02h idx %0d len %0d last %0b",
                 $time, pkt_byte, byte_index, frame_len, last);
        err_cnt++;
      end else begin
        beat_want = pending_bytes_q.pop_front();
        beats_seen++;
        if (beat_got !== beat_want) begin
          $display("%0t: packet byte mismatch: expected data %02h idx %0d len %0d last %0b",
                   $time, beat_want.data, beat_want.index, beat_want.len, beat_want.last);
          $display("%0t:                       actual data %02h idx %0d len %0d last %0b",
                   $time, beat_got.data, beat_got.index, beat_got.len, beat_got.last);
          err_cnt++;
        end
      end
    end
  end

  // Drive output stall: random short and long stalls, burst stretches, one long hold.
  always @(negedge clk) begin
    int r;
    if (hold_left == 0 && !hold_done && beats_seen >= 300) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) burst_rx = !burst_rx;
      r = $urandom_range(0, 99);
      if (burst_rx || r < 65) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
        out_stall <= 1'b1;
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    dir_row_t   row;
    int         k;
    int         n;
    int         ph;
    int         phase_start;
    int         frames;
    logic [6:0] cur_min;

    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    rx_byte    = '0;
    out_stall  = 1'b0;
    err_cnt    = 0;
    beats_seen = 0;
    bytes_sent = 0;
    cycle_cnt  = 0;
    burst_tx   = 1'b0;
    burst_rx   = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    pred_esc   = 1'b0;
    pred_count = '0;
    pred_len   = '0;
    pred_min   = MIN_FRAME_RST;
    for (k = 0; k < PKT_BYTES; k++) pred_store[k] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (k = 0; k < 25; k++) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) begin
        set_min_frame(row.value[6:0]);
      end else begin
        send_byte(row.value, n);
        if (row.typed && (n != (row.delivers ? PKT_BYTES : 0) ||
                          (row.delivers && pred_len != row.len))) begin
          $display("%0t: directed row %0d expected %0d bytes len %0d, got %0d bytes len %0d",
                   $time, k, row.delivers ? PKT_BYTES : 0, row.len, n, pred_len);
          err_cnt++;
        end
      end
    end

    // random frames over several frame minimums
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       cur_min = 7'd1;
        1:       cur_min = 7'd64;
        2:       cur_min = 7'd5;
        default: cur_min = 7'($urandom_range(1, 16));
      endcase
      set_min_frame(cur_min);
      phase_start = bytes_sent;
      frames = 0;
      while (frames < 1 || bytes_sent - phase_start < 30) begin
        burst_tx = ($urandom_range(0, 3) == 0);
        if (cur_min == 7'd64 || $urandom_range(0, 99) < 8) begin
          send_frame($urandom_range(60, 72));
        end else begin
          send_frame($urandom_range(0, 14));
        end
        frames++;
      end
    end

    // drain and settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes_q.size() != 0) @(posedge clk);
    repeat (PKT_BYTES + 16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/hdlc_dfr_pkg.sv
rtl/core/hdlc_dfr_ctrl.sv
rtl/core/hdlc_dfr_dpath.sv
rtl/core/hdlc_async_deframer.sv
tb/testbench.sv
